@@ design/igt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igt_pkg
// Shared types, codes and sizes of the image geometry transform block.
// ----------------------------------------------------------------------------
package igt_pkg;

  // Default largest source dimension, and the fixed field widths.
  localparam int MAX_DIM_DEF = 256;
  localparam int DIM_W       = 9;
  localparam int NUM_W       = 18;
  localparam int SIZE_W      = 18;
  localparam int PIX_W       = 24;

  // Input commands.
  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_EMIT   = 2'd2;

  // Transform modes.
  localparam logic [2:0] MODE_FLIPH   = 3'd0;
  localparam logic [2:0] MODE_FLIPV   = 3'd1;
  localparam logic [2:0] MODE_ROTL    = 3'd2;
  localparam logic [2:0] MODE_ROTR    = 3'd3;
  localparam logic [2:0] MODE_CROP    = 3'd4;
  localparam logic [2:0] MODE_SCALE   = 3'd5;
  localparam logic [2:0] MODE_EXTRACT = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_CROP_SX = 3'd1;
  localparam logic [2:0] CFG_CROP_SY = 3'd2;
  localparam logic [2:0] CFG_CROP_W  = 3'd3;
  localparam logic [2:0] CFG_CROP_H  = 3'd4;
  localparam logic [2:0] CFG_SCALE   = 3'd5;
  localparam logic [2:0] CFG_KEEP    = 3'd6;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_HW, ST_HH, ST_HEVAL, ST_HAREA, ST_HSIZE, ST_HFIN,
    ST_EADDR, ST_SRM, ST_SRS, ST_SRW, ST_SCM, ST_SCS, ST_SCW,
    ST_IDXM, ST_IDX, ST_RD, ST_PUT
  } state_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DIM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ design/igt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igt_div
// Restoring divider, one quotient bit per cycle, for the scale source index.
// ----------------------------------------------------------------------------
module igt_div
  import igt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DIM_W-1:0] rem_r;
  logic [DIM_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIM_W:0]   trial;
  logic             ge;

  // One step: bring down the next numerator bit and try a subtraction.
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        rem_r  <= '0;
        quo_r  <= req.num;
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= ge ? DIM_W'(trial - {1'b0, den_r}) : trial[DIM_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ design/igt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igt_store
// Frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module igt_store
  import igt_pkg::*;
#(
  parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
  parameter int AW    = 2 * $clog2(MAX_DIM_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  // Write side.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read side, data registered and valid in the cycle after the request.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/image_geometry_transform_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_geometry_transform_top
// Loads one RGB frame into a frame store and reads it out flipped, rotated,
// cropped, scaled or channel-masked, one pixel per emit request.
// ----------------------------------------------------------------------------
// A header result steps through HW, HH, HEVAL, HAREA, HSIZE and HFIN to PUT,
// set by the shared multiplier used four times. An emit result steps through
// EADDR, IDXM, IDX and RD to PUT, with SRM to SCW after EADDR in scale mode,
// where the two source indexes come from an 18-step bit-serial divider used
// twice. Next request is taken in the cycle after each result is registered.
// Reset is synchronous and active low; it clears control state and config
// registers only. The frame store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module image_geometry_transform_top
  import igt_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: frame_width[8:0], frame_height[17:9], red_in[25:18],
  //        green_in[33:26], blue_in[41:34], zero fill
  input  logic [47:0] in_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: red_out[7:0], green_out[15:8], blue_out[23:16], out_width[32:24],
  //        out_height[41:33], out_image_size[59:42], zero fill
  output logic [63:0] out_tdata,
  // tuser: invalid[0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = 2 * $clog2(MAX_DIM);
  localparam int LW    = (AW + 1 > NUM_W) ? AW + 1 : NUM_W;

  // Configuration registers.
  logic [2:0]       mode_r, km_r;
  logic [DIM_W-1:0] csx_r, csy_r, cw_r, ch_r;
  logic [15:0]      sf_r;

  // Frame state.
  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r, col_r, row_r;
  logic [DIM_W-1:0] sr_r, sc_r;
  logic [LW-1:0]    load_idx_r;
  logic [NUM_W-1:0] area_r;
  logic [SIZE_W-1:0] size_r;
  logic             bad_r, hdr_r;
  logic [24:0]      prod_w_r;
  logic [33:0]      prod_r;
  logic [AW-1:0]    idx_r;
  logic             idx_ok_r;

  // Output register.
  logic             out_valid_r, out_last_r, out_inv_r;
  logic [63:0]      out_data_r;

  // Input fields.
  logic [DIM_W-1:0] in_fw, in_fh;
  logic [PIX_W-1:0] in_pix;
  logic             in_acc;

  // Shared multiplier operands.
  logic [17:0]      mul_a;
  logic [15:0]      mul_b;

  // Header evaluation.
  logic [25:0]      sum_w, sum_h;
  logic [17:0]      sdw, sdh;
  logic [9:0]       crop_x_end, crop_y_end;
  logic [DIM_W-1:0] ev_dw, ev_dh;
  logic             ev_bad;
  logic [9:0]       row_bytes;

  // Emit address.
  logic [9:0]       ea_sr, ea_sc;
  logic [LW:0]      idx_sum;
  logic             emit_go;

  // Store and divider.
  logic             st_we, st_re;
  logic [AW-1:0]    st_waddr;
  logic [PIX_W-1:0] st_rdata, pix_m;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             put_ok;

  assign in_fw  = in_tdata[8:0];
  assign in_fh  = in_tdata[17:9];
  assign in_pix = {in_tdata[41:34], in_tdata[33:26], in_tdata[25:18]};
  assign in_acc = in_tvalid && in_tready;
  assign put_ok = !out_valid_r || out_tready;

  igt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_pix),
    .re    (st_re),
    .raddr (idx_r),
    .rdata (st_rdata)
  );

  igt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FLIPH;
      csx_r  <= '0;
      csy_r  <= '0;
      cw_r   <= DIM_W'(1);
      ch_r   <= DIM_W'(1);
      sf_r   <= 16'd256;
      km_r   <= 3'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r <= cfg_wdata[2:0];
        CFG_CROP_SX: csx_r  <= cfg_wdata[8:0];
        CFG_CROP_SY: csy_r  <= cfg_wdata[8:0];
        CFG_CROP_W:  cw_r   <= cfg_wdata[8:0];
        CFG_CROP_H:  ch_r   <= cfg_wdata[8:0];
        CFG_SCALE:   sf_r   <= cfg_wdata;
        CFG_KEEP:    km_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection.
  assign row_bytes = 10'((11'(dst_w_r) * 11'd3 + 11'd3) & ~11'd3);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_HW:    begin mul_a = 18'(src_w_r);   mul_b = sf_r;           end
      ST_HH:    begin mul_a = 18'(src_h_r);   mul_b = sf_r;           end
      ST_HAREA: begin mul_a = 18'(src_w_r);   mul_b = 16'(src_h_r);   end
      ST_HSIZE: begin mul_a = 18'(row_bytes); mul_b = 16'(dst_h_r);   end
      ST_SRM:   begin mul_a = 18'(row_r);     mul_b = 16'(src_h_r);   end
      ST_SCM:   begin mul_a = 18'(col_r);     mul_b = 16'(src_w_r);   end
      ST_IDXM:  begin mul_a = 18'(sr_r);      mul_b = 16'(src_w_r);   end
      default: ;
    endcase
  end

  // Header check: output size and validity for the current mode.
  always_comb begin
    sum_w      = 26'(prod_w_r) + 26'd128;
    sum_h      = 26'(prod_r[24:0]) + 26'd128;
    sdw        = sum_w[25:8];
    sdh        = sum_h[25:8];
    crop_x_end = 10'(csx_r) + 10'(cw_r);
    crop_y_end = 10'(csy_r) + 10'(ch_r);
    ev_dw      = '0;
    ev_dh      = '0;
    ev_bad     = 1'b0;
    if (src_w_r == '0 || src_h_r == '0 ||
        32'(src_w_r) > MAX_DIM || 32'(src_h_r) > MAX_DIM) begin
      ev_bad = 1'b1;
    end else begin
      case (mode_r)
        MODE_FLIPH, MODE_FLIPV, MODE_EXTRACT: begin
          ev_dw  = src_w_r;
          ev_dh  = src_h_r;
          ev_bad = (mode_r == MODE_EXTRACT) && (km_r == 3'd0);
        end
        MODE_ROTL, MODE_ROTR: begin
          ev_dw = src_h_r;
          ev_dh = src_w_r;
        end
        MODE_CROP: begin
          ev_dw  = cw_r;
          ev_dh  = ch_r;
          ev_bad = (cw_r == '0) || (ch_r == '0) ||
                   (crop_x_end > 10'(src_w_r)) || (crop_y_end > 10'(src_h_r));
        end
        MODE_SCALE: begin
          ev_dw  = sdw[DIM_W-1:0];
          ev_dh  = sdh[DIM_W-1:0];
          ev_bad = (sf_r == 16'd0) || (32'(sdw) > MAX_DIM) || (32'(sdh) > MAX_DIM);
        end
        default: ev_bad = 1'b1;
      endcase
    end
    if (ev_bad) begin
      ev_dw = '0;
      ev_dh = '0;
    end
  end

  // Source coordinates for the modes that need no division.
  always_comb begin
    ea_sr = 10'(row_r);
    ea_sc = 10'(col_r);
    case (mode_r)
      MODE_FLIPH: ea_sc = 10'(src_w_r) - 10'd1 - 10'(col_r);
      MODE_FLIPV: ea_sr = 10'(src_h_r) - 10'd1 - 10'(row_r);
      MODE_ROTL: begin
        ea_sr = 10'(dst_w_r) - 10'd1 - 10'(col_r);
        ea_sc = 10'(row_r);
      end
      MODE_ROTR: begin
        ea_sr = 10'(col_r);
        ea_sc = 10'(src_w_r) - 10'd1 - 10'(row_r);
      end
      MODE_CROP: begin
        ea_sr = 10'(src_h_r) - 10'(ch_r) - 10'(csy_r) + 10'(row_r);
        ea_sc = 10'(csx_r) + 10'(col_r);
      end
      default: ;
    endcase
  end

  assign idx_sum = (LW + 1)'(prod_r[NUM_W-1:0]) + (LW + 1)'(sc_r);
  assign emit_go = !bad_r && dst_w_r != '0 && dst_h_r != '0 &&
                   row_r < dst_h_r && col_r < dst_w_r;

  // Store write for a load request within the frame.
  always_comb begin
    st_we    = in_acc && in_tuser == CMD_LOAD &&
               load_idx_r < LW'(area_r) && 32'(load_idx_r) < DEPTH;
    st_waddr = load_idx_r[AW-1:0];
  end

  // Sequencer: next state and unit controls.
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    st_re       = 1'b0;
    div_req     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            CMD_HEADER: state_nxt = ST_HW;
            CMD_EMIT:   if (emit_go) state_nxt = ST_EADDR;
            default: ;
          endcase
        end
      end
      ST_HW:    state_nxt = ST_HH;
      ST_HH:    state_nxt = ST_HEVAL;
      ST_HEVAL: state_nxt = ST_HAREA;
      ST_HAREA: state_nxt = ST_HSIZE;
      ST_HSIZE: state_nxt = ST_HFIN;
      ST_HFIN:  state_nxt = ST_PUT;
      ST_EADDR: state_nxt = (mode_r == MODE_SCALE) ? ST_SRM : ST_IDXM;
      ST_SRM:   state_nxt = ST_SRS;
      ST_SRS: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r[NUM_W-1:0];
        div_req.den   = dst_h_r;
        state_nxt     = ST_SRW;
      end
      ST_SRW:   if (div_rsp.done) state_nxt = ST_SCM;
      ST_SCM:   state_nxt = ST_SCS;
      ST_SCS: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r[NUM_W-1:0];
        div_req.den   = dst_w_r;
        state_nxt     = ST_SCW;
      end
      ST_SCW:   if (div_rsp.done) state_nxt = ST_IDXM;
      ST_IDXM:  state_nxt = ST_IDX;
      ST_IDX:   state_nxt = ST_RD;
      ST_RD: begin
        st_re     = 1'b1;
        state_nxt = ST_PUT;
      end
      ST_PUT:   if (put_ok) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r    <= '0;
      src_h_r    <= '0;
      dst_w_r    <= '0;
      dst_h_r    <= '0;
      col_r      <= '0;
      row_r      <= '0;
      load_idx_r <= '0;
      area_r     <= '0;
      size_r     <= '0;
      bad_r      <= 1'b0;
      hdr_r      <= 1'b0;
    end else begin
      if (st_we) begin
        load_idx_r <= load_idx_r + 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_tuser == CMD_HEADER) begin
            src_w_r    <= in_fw;
            src_h_r    <= in_fh;
            load_idx_r <= '0;
            col_r      <= '0;
            row_r      <= '0;
            hdr_r      <= 1'b1;
          end else if (in_acc && in_tuser == CMD_EMIT) begin
            hdr_r <= 1'b0;
          end
        end
        ST_HEVAL: begin
          dst_w_r <= ev_dw;
          dst_h_r <= ev_dh;
          bad_r   <= ev_bad;
        end
        ST_HSIZE: area_r <= prod_r[NUM_W-1:0];
        ST_HFIN:  size_r <= prod_r[SIZE_W-1:0];
        ST_PUT: begin
          if (put_ok && !hdr_r) begin
            if (col_r + 1'b1 >= dst_w_r) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: products, coordinates and the store address.
  always_ff @(posedge clk) begin
    prod_r <= 34'(mul_a) * 34'(mul_b);
    if (state_r == ST_HH) begin
      prod_w_r <= prod_r[24:0];
    end
    if (state_r == ST_EADDR) begin
      sr_r <= ea_sr[DIM_W-1:0];
      sc_r <= ea_sc[DIM_W-1:0];
    end
    if (state_r == ST_SRW && div_rsp.done) begin
      sr_r <= div_rsp.quo[DIM_W-1:0];
    end
    if (state_r == ST_SCW && div_rsp.done) begin
      sc_r <= div_rsp.quo[DIM_W-1:0];
    end
    if (state_r == ST_IDX) begin
      idx_r    <= idx_sum[AW-1:0];
      idx_ok_r <= 32'(idx_sum) < DEPTH;
    end
  end

  // Channel masking in extract mode; a read beyond the store gives black.
  always_comb begin
    pix_m = idx_ok_r ? st_rdata : '0;
    if (mode_r == MODE_EXTRACT) begin
      if (!km_r[0]) pix_m[7:0]   = '0;
      if (!km_r[1]) pix_m[15:8]  = '0;
      if (!km_r[2]) pix_m[23:16] = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_PUT && put_ok) begin
        out_valid_r <= 1'b1;
        out_inv_r   <= bad_r;
        out_last_r  <= !hdr_r && row_r == dst_h_r - 1'b1 && col_r == dst_w_r - 1'b1;
        out_data_r  <= {4'd0, size_r, dst_h_r, dst_w_r, hdr_r ? 24'd0 : pix_m};
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_inv_r;

  // A result flagged invalid never closes a frame.
  a_inv_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("invalid result marked as last pixel");

  // Loads never run past the store.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> 32'(load_idx_r) < DEPTH)
    else $error("load index beyond frame store");

  // The divider is only started from the scale steps.
  a_div_scale: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> mode_r == MODE_SCALE && !bad_r)
    else $error("divider started outside scale mode");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame-store geometry transform block. Frames
// of random size are loaded and read back in every mode, including invalid
// settings, zero-sized scale output and stray requests. Each accepted
// request is fed to a scoreboard that works out the expected result, and
// each result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import igt_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam int         CYCLE_LIMIT = 1500000;
  localparam int         ITEM_TARGET = 650;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [8:0]  width;
    logic [8:0]  height;
    logic [17:0] size;
    logic        last;
    logic        invalid;
  } pixel_result_t;

  // Scoreboard: own copy of configuration, frame store and read-out position.
  class igt_scoreboard;
    logic [23:0]   store [65536];
    logic [2:0]    mode;
    logic [8:0]    crop_sx, crop_sy, crop_w, crop_h;
    logic [15:0]   factor;
    logic [2:0]    keep;
    int unsigned   src_w, src_h, load_idx, col, row, dst_w, dst_h;
    bit            bad;
    pixel_result_t awaited_q[$];
    int            errors;

    function new();
      mode = MODE_FLIPH; crop_sx = 9'd0; crop_sy = 9'd0; crop_w = 9'd1; crop_h = 9'd1;
      factor = 16'd256; keep = 3'd7;
      src_w = 0; src_h = 0; load_idx = 0; col = 0; row = 0;
      dst_w = 0; dst_h = 0; bad = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        CFG_MODE:    mode    = v[2:0];
        CFG_CROP_SX: crop_sx = v[8:0];
        CFG_CROP_SY: crop_sy = v[8:0];
        CFG_CROP_W:  crop_w  = v[8:0];
        CFG_CROP_H:  crop_h  = v[8:0];
        CFG_SCALE:   factor  = v;
        CFG_KEEP:    keep    = v[2:0];
        default: ;
      endcase
    endfunction

    function pixel_result_t make_result(logic [23:0] pix, bit last);
      pixel_result_t res;
      int unsigned   row_bytes;
      row_bytes   = (dst_w * 3 + 3) & ~32'd3;
      res.red     = pix[7:0];
      res.green   = pix[15:8];
      res.blue    = pix[23:16];
      res.width   = dst_w[8:0];
      res.height  = dst_h[8:0];
      res.size    = 18'(row_bytes * dst_h);
      res.last    = last;
      res.invalid = bad;
      return res;
    endfunction

    function void latch_header(int unsigned w, int unsigned h);
      int unsigned dw, dh;
      bit          b;
      dw = 0; dh = 0; b = 0;
      src_w = w; src_h = h; load_idx = 0; col = 0; row = 0;
      if (w == 0 || h == 0 || w > MAX_DIM_DEF || h > MAX_DIM_DEF) begin
        b = 1;
      end else if (mode == MODE_FLIPH || mode == MODE_FLIPV ||
                   mode == MODE_EXTRACT) begin
        dw = w; dh = h;
        if (mode == MODE_EXTRACT && keep == 0) b = 1;
      end else if (mode == MODE_ROTL || mode == MODE_ROTR) begin
        dw = h; dh = w;
      end else if (mode == MODE_CROP) begin
        if (crop_w == 0 || crop_h == 0 || crop_sx + crop_w > w ||
            crop_sy + crop_h > h) b = 1;
        dw = crop_w; dh = crop_h;
      end else if (mode == MODE_SCALE) begin
        if (factor == 0) b = 1;
        dw = (w * factor + 128) >> 8;
        dh = (h * factor + 128) >> 8;
        if (dw > MAX_DIM_DEF || dh > MAX_DIM_DEF) b = 1;
      end else begin
        b = 1;
      end
      if (b) begin
        dw = 0; dh = 0;
      end
      dst_w = dw; dst_h = dh; bad = b;
    endfunction

    function logic [23:0] source_pixel(int unsigned c, int unsigned r);
      int unsigned sr, sc, idx;
      logic [23:0] pix;
      case (mode)
        MODE_FLIPH: begin sr = r; sc = src_w - 1 - c; end
        MODE_FLIPV: begin sr = src_h - 1 - r; sc = c; end
        MODE_ROTL:  begin sr = dst_w - 1 - c; sc = r; end
        MODE_ROTR:  begin sr = c; sc = src_w - 1 - r; end
        MODE_CROP:  begin sr = src_h - crop_h - crop_sy + r; sc = crop_sx + c; end
        MODE_SCALE: begin sr = (r * src_h) / dst_h; sc = (c * src_w) / dst_w; end
        default:    begin sr = r; sc = c; end
      endcase
      idx = sr * src_w + sc;
      pix = (idx < 65536) ? store[idx] : 24'd0;
      if (mode == MODE_EXTRACT) begin
        if (!keep[0]) pix[7:0]   = 8'd0;
        if (!keep[1]) pix[15:8]  = 8'd0;
        if (!keep[2]) pix[23:16] = 8'd0;
      end
      return pix;
    endfunction

    // Note one accepted request and queue the result it causes, if any.
    function void note_request(logic [1:0] cmd, logic [47:0] d);
      bit last;
      case (cmd)
        CMD_HEADER: begin
          latch_header(32'(d[8:0]), 32'(d[17:9]));
          awaited_q.push_back(make_result(24'd0, 0));
        end
        CMD_LOAD: begin
          if (load_idx < src_w * src_h && load_idx < 65536) begin
            store[load_idx] = {d[41:34], d[33:26], d[25:18]};
            load_idx++;
          end
        end
        CMD_EMIT: begin
          if (!(bad || dst_w == 0 || dst_h == 0 || row >= dst_h || col >= dst_w)) begin
            last = (row == dst_h - 1) && (col == dst_w - 1);
            awaited_q.push_back(make_result(source_pixel(col, row), last));
            col++;
            if (col >= dst_w) begin
              col = 0;
              row++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [63:0] d, logic inv, logic last);
      pixel_result_t exp_r, got;
      got = '{red: d[7:0], green: d[15:8], blue: d[23:16], width: d[32:24],
              height: d[41:33], size: d[59:42], last: last, invalid: inv};
      if (awaited_q.size() == 0) begin
        $display("%0t: result with none awaited, actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = awaited_q.pop_front();
      if (got.red != exp_r.red || got.green != exp_r.green ||
          got.blue != exp_r.blue) begin
        $display("%0t: pixel expected %h %h %h actual %h %h %h", $time,
                 exp_r.red, exp_r.green, exp_r.blue, got.red, got.green, got.blue);
        errors++;
      end
      if (got.width != exp_r.width || got.height != exp_r.height) begin
        $display("%0t: size expected %0d x %0d actual %0d x %0d", $time,
                 exp_r.width, exp_r.height, got.width, got.height);
        errors++;
      end
      if (got.size != exp_r.size) begin
        $display("%0t: image size expected %0d actual %0d", $time,
                 exp_r.size, got.size);
        errors++;
      end
      if (got.last != exp_r.last) begin
        $display("%0t: tlast expected %b actual %b", $time, exp_r.last, got.last);
        errors++;
      end
      if (got.invalid != exp_r.invalid) begin
        $display("%0t: invalid expected %b actual %b", $time,
                 exp_r.invalid, got.invalid);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  igt_scoreboard sb;
  int            sent;
  int            cycles;
  int            hold_cycles;
  bit            steady;

  image_geometry_transform_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("image_geometry_transform_top: mismatch");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random back-pressure, or a long hold-off when one is asked for.
  initial begin
    out_tready = 0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
        @(posedge clk);
      end else begin
        automatic int g = pick_gap();
        out_tready <= (g == 0);
        repeat (g == 0 ? $urandom_range(1, 6) : g) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [47:0] d);
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, d);
    sent++;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_header(int unsigned w, int unsigned h);
    send_request(CMD_HEADER, {30'd0, h[8:0], w[8:0]});
  endtask

  task automatic send_pixel();
    send_request(CMD_LOAD, {6'd0, 24'($urandom), 18'($urandom)});
  endtask

  task automatic send_emit();
    send_request(CMD_EMIT, 48'({$urandom, $urandom}));
  endtask

  // Wait for all results, then for an emit that may still be in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we    <= 1'b0;
  endtask

  // One frame: settings, header, full load, read-out with some extras.
  task automatic run_frame(logic [2:0] md, int unsigned w, int unsigned h,
                           int unsigned sx, int unsigned sy, int unsigned cw,
                           int unsigned ch, int unsigned f, int unsigned km,
                           int long_hold);
    int n;
    drain();
    write_reg(CFG_MODE, 16'(md));
    write_reg(CFG_CROP_SX, 16'(sx));
    write_reg(CFG_CROP_SY, 16'(sy));
    write_reg(CFG_CROP_W, 16'(cw));
    write_reg(CFG_CROP_H, 16'(ch));
    write_reg(CFG_SCALE, 16'(f));
    write_reg(CFG_KEEP, 16'(km));
    if ($urandom_range(0, 9) == 0) send_request(CMD_NONE, 48'($urandom));
    send_header(w, h);
    if (w >= 1 && w <= MAX_DIM_DEF && h >= 1 && h <= MAX_DIM_DEF) begin
      n = w * h + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
    end else begin
      n = $urandom_range(0, 3);
    end
    repeat (n) send_pixel();
    if (long_hold != 0) hold_cycles = 400;
    if (sb.bad) n = $urandom_range(1, 2);
    else n = sb.dst_w * sb.dst_h + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(CMD_NONE, 48'($urandom));
      send_emit();
    end
  endtask

  initial begin
    logic [2:0]  md;
    int unsigned w, h;
    int unsigned sx, sy, cw, ch;
    int unsigned f;
    int unsigned km;
    int          frame;
    sb = new();
    sent = 0; cycles = 0; hold_cycles = 0; steady = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = CMD_HEADER;
    cfg_we = 0; cfg_index = CFG_MODE; cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests before any header yield nothing.
    send_emit();
    send_pixel();
    send_request(CMD_NONE, '1);

    // Directed frames: size extremes and invalid settings.
    run_frame(MODE_FLIPH, 0, 3, 0, 0, 1, 1, 256, 7, 0);
    run_frame(MODE_FLIPV, 511, 511, 0, 0, 1, 1, 256, 7, 0);
    run_frame(MODE_UNUSED, 2, 2, 0, 0, 1, 1, 256, 7, 0);
    run_frame(MODE_EXTRACT, 1, 1, 0, 0, 1, 1, 256, 0, 0);
    run_frame(MODE_SCALE, 2, 2, 0, 0, 1, 1, 0, 7, 0);
    run_frame(MODE_SCALE, 1, 2, 0, 0, 1, 1, 16'hFFFF, 7, 0);
    run_frame(MODE_SCALE, 2, 1, 0, 0, 1, 1, 16'hFFFF, 7, 0);
    run_frame(MODE_SCALE, 1, 1, 0, 0, 1, 1, 100, 7, 0);
    run_frame(MODE_CROP, 3, 2, 2, 0, 2, 1, 256, 7, 0);
    run_frame(MODE_CROP, 2, 2, 0, 0, 0, 1, 256, 7, 0);
    run_frame(MODE_ROTR, 24, 1, 0, 0, 1, 1, 256, 7, 1);
    run_frame(MODE_ROTL, 1, 24, 0, 0, 1, 1, 256, 7, 0);
    run_frame(MODE_CROP, 256, 1, 255, 0, 1, 1, 256, 7, 0);

    // Random frames, mostly small and well formed.
    frame = 0;
    while (sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 5) == 0);
      md = ($urandom_range(0, 29) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
      w  = $urandom_range(1, 6);
      h  = $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(7, 20);
        h = $urandom_range(1, 3);
      end
      if ($urandom_range(0, 24) == 0) w = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
      cw = $urandom_range(1, w > 0 && w <= 256 ? w : 1);
      ch = $urandom_range(1, h);
      sx = $urandom_range(0, w > cw ? w - cw : 0);
      sy = $urandom_range(0, h - ch);
      if ($urandom_range(0, 7) == 0) begin
        sx = $urandom_range(0, 256); sy = $urandom_range(0, 256);
        cw = $urandom_range(0, 256); ch = $urandom_range(0, 256);
      end
      f  = $urandom_range(32, 700);
      if ($urandom_range(0, 14) == 0) f = 0;
      km = $urandom_range(0, 7);
      run_frame(md, w, h, sx, sy, cw, ch, f, km, (frame == 4) ? 1 : 0);
      frame++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.awaited_q.size() != 0) begin
      $display("%0t: %0d results expected, none arrived", $time, sb.awaited_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("image_geometry_transform_top: match");
    end else begin
      $display("image_geometry_transform_top: mismatch");
    end
    $finish;
  end

endmodule
